[rtl/huffman_tree_decoder_macros.svh]
// assertion macros for the huffman tree decoder
`ifndef HUFFMAN_TREE_DECODER_MACROS_SVH
`define HUFFMAN_TREE_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// property that must hold at every clock edge out of reset
`define HTD_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("htd assertion failed");

// consequent must hold in the cycle after the antecedent
`define HTD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("htd assertion failed");

`else

`define HTD_ASSERT_ALWAYS(lbl, prop)
`define HTD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/htd_pkg.sv]
// types, constants and codes shared by the huffman tree decoder
`timescale 1ns / 1ps
`default_nettype none

package htd_pkg;

	localparam int NODE_COUNT   = 512;
	localparam int MAX_CODE_LEN = 16;

	localparam int NODE_W   = $clog2(NODE_COUNT);
	localparam int CNT_W    = $clog2(NODE_COUNT + 1);
	localparam int KLEN_W   = $clog2(MAX_CODE_LEN + 1);
	localparam int SYM_W    = 8;
	localparam int CODE_W   = 16;
	localparam int LEN_W    = 5;
	localparam int STATUS_W = 3;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_DECODE = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_BIT      = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_SYMBOL   = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_ABSENT   = 3'd4;

	typedef struct packed {
		logic              kind;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_len;
		logic              message_bit;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SYM_W-1:0]    decoded_symbol;
	} result_t;

	// read and write request to the node store
	typedef struct packed {
		logic [NODE_W-1:0] rd_addr;
		logic [NODE_W-1:0] wr_addr;
		logic              left_we;
		logic              right_we;
		logic [NODE_W-1:0] link_data;
		logic              sym_we;
		logic [SYM_W-1:0]  sym_data;
	} store_req_t;

	// node contents, in the cycle after the read address
	typedef struct packed {
		logic [NODE_W-1:0] left;
		logic [NODE_W-1:0] right;
		logic [SYM_W-1:0]  sym;
	} node_rd_t;

	typedef struct packed {
		logic    valid;
		result_t res;
	} fin_t;

endpackage

`default_nettype wire

[rtl/htd_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module htd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/htd_store.sv]
// node store: child link and symbol memories, root links in flops
`timescale 1ns / 1ps
`default_nettype none

module htd_store (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire htd_pkg::store_req_t req,
	output htd_pkg::node_rd_t       rd
);

	logic [htd_pkg::NODE_W-1:0] left_ram;
	logic [htd_pkg::NODE_W-1:0] right_ram;
	logic [htd_pkg::SYM_W-1:0]  sym_ram;
	logic [htd_pkg::NODE_W-1:0] root_left_q;
	logic [htd_pkg::NODE_W-1:0] root_right_q;
	logic                       rd_root_q;
	logic                       wr_root;

	htd_ram #(.WIDTH(htd_pkg::NODE_W), .DEPTH(htd_pkg::NODE_COUNT)) u_left (
		.clk   (clk),
		.we    (req.left_we),
		.waddr (req.wr_addr),
		.wdata (req.link_data),
		.raddr (req.rd_addr),
		.rdata (left_ram)
	);

	htd_ram #(.WIDTH(htd_pkg::NODE_W), .DEPTH(htd_pkg::NODE_COUNT)) u_right (
		.clk   (clk),
		.we    (req.right_we),
		.waddr (req.wr_addr),
		.wdata (req.link_data),
		.raddr (req.rd_addr),
		.rdata (right_ram)
	);

	htd_ram #(.WIDTH(htd_pkg::SYM_W), .DEPTH(htd_pkg::NODE_COUNT)) u_sym (
		.clk   (clk),
		.we    (req.sym_we),
		.waddr (req.wr_addr),
		.wdata (req.sym_data),
		.raddr (req.rd_addr),
		.rdata (sym_ram)
	);

	assign wr_root = (req.wr_addr == '0);

	// root links live in flops so that reset leaves an empty tree
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_left_q  <= '0;
			root_right_q <= '0;
			rd_root_q    <= 1'b0;
		end else begin
			if (req.left_we && wr_root) begin
				root_left_q <= req.link_data;
			end
			if (req.right_we && wr_root) begin
				root_right_q <= req.link_data;
			end
			rd_root_q <= (req.rd_addr == '0);
		end
	end

	assign rd.left  = rd_root_q ? root_left_q : left_ram;
	assign rd.right = rd_root_q ? root_right_q : right_ram;
	assign rd.sym   = sym_ram;

endmodule

`default_nettype wire

[rtl/htd_ctrl.sv]
// sequencer that walks the tree for inserts and steps the cursor for decodes
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_tree_decoder_macros.svh"

module htd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire htd_pkg::item_t      item,
	input  wire logic                take,
	input  wire logic                out_free,
	input  wire htd_pkg::node_rd_t   rd,
	output htd_pkg::store_req_t      req,
	output htd_pkg::fin_t            fin,
	output logic                     idle
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_WALK   = 3'd1;
	localparam logic [2:0] S_CHK    = 3'd2;
	localparam logic [2:0] S_INIT   = 3'd3;
	localparam logic [2:0] S_WSYM   = 3'd4;
	localparam logic [2:0] S_DCHILD = 3'd5;
	localparam logic [2:0] S_DLEAF  = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	localparam int POS_W = $clog2(htd_pkg::CODE_W);

	logic [2:0]                 state_q, state_d;
	logic [htd_pkg::NODE_W-1:0] p_q, p_d;
	logic [htd_pkg::NODE_W-1:0] c_q, c_d;
	logic [htd_pkg::NODE_W-1:0] cursor_q, cursor_d;
	logic [htd_pkg::CNT_W-1:0]  used_q, used_d;
	logic [htd_pkg::KLEN_W-1:0] k_q, k_d;
	logic [htd_pkg::CODE_W-1:0] code_q;
	logic [htd_pkg::SYM_W-1:0]  sym_q;
	logic                       bit_q;
	htd_pkg::result_t           res_q, res_d;

	logic [htd_pkg::KLEN_W-1:0] len_clamp;
	logic [htd_pkg::NODE_W-1:0] new_node;
	logic [htd_pkg::NODE_W-1:0] child;
	logic                       cbit;
	logic                       done;
	htd_pkg::result_t           res_now;

	// code bit for k remaining bits; positions past the field read as zero
	function automatic logic pick_bit(input logic [htd_pkg::CODE_W-1:0] code,
			input logic [htd_pkg::KLEN_W-1:0] k);
		logic [31:0] pos;
		pos = 32'(k) - 32'd1;
		return (pos < htd_pkg::CODE_W) ? code[pos[POS_W-1:0]] : 1'b0;
	endfunction

	assign len_clamp = (item.code_len > htd_pkg::LEN_W'(htd_pkg::MAX_CODE_LEN)) ?
		htd_pkg::KLEN_W'(htd_pkg::MAX_CODE_LEN) : htd_pkg::KLEN_W'(item.code_len);
	assign new_node = used_q[htd_pkg::NODE_W-1:0];
	assign cbit     = pick_bit(code_q, k_q);
	assign idle     = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		p_d      = p_q;
		c_d      = c_q;
		k_d      = k_q;
		cursor_d = cursor_q;
		used_d   = used_q;
		res_d    = res_q;
		req      = '0;
		req.rd_addr = p_q;
		fin      = '0;
		done     = 1'b0;
		res_now  = '0;
		child    = '0;
		case (state_q)
			S_IDLE: begin
				req.rd_addr = cursor_q;
				if (take) begin
					if (item.kind == htd_pkg::KIND_INSERT) begin
						p_d     = '0;
						k_d     = len_clamp;
						state_d = (len_clamp == '0) ? S_WSYM : S_WALK;
					end else begin
						state_d = S_DCHILD;
					end
				end
			end
			S_WALK: begin
				state_d = S_CHK;
			end
			S_CHK: begin
				child = cbit ? rd.right : rd.left;
				if (child != '0) begin
					p_d = child;
					if (k_q == htd_pkg::KLEN_W'(1)) begin
						req.wr_addr  = child;
						req.sym_we   = 1'b1;
						req.sym_data = sym_q;
						done            = 1'b1;
						res_now.status  = htd_pkg::STAT_INSERTED;
					end else begin
						k_d     = htd_pkg::KLEN_W'(k_q - 1'b1);
						state_d = S_WALK;
					end
				end else if (used_q == htd_pkg::CNT_W'(htd_pkg::NODE_COUNT)) begin
					done           = 1'b1;
					res_now.status = htd_pkg::STAT_FULL;
				end else begin
					// hang a fresh node under the parent, clear it next cycle
					req.wr_addr   = p_q;
					req.left_we   = !cbit;
					req.right_we  = cbit;
					req.link_data = new_node;
					p_d     = new_node;
					used_d  = htd_pkg::CNT_W'(used_q + 1'b1);
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				req.wr_addr   = p_q;
				req.left_we   = 1'b1;
				req.right_we  = 1'b1;
				req.link_data = '0;
				req.sym_we    = 1'b1;
				if (k_q == htd_pkg::KLEN_W'(1)) begin
					req.sym_data   = sym_q;
					done           = 1'b1;
					res_now.status = htd_pkg::STAT_INSERTED;
				end else begin
					req.sym_data = '0;
					k_d     = htd_pkg::KLEN_W'(k_q - 1'b1);
					state_d = S_WALK;
				end
			end
			S_WSYM: begin
				req.wr_addr    = p_q;
				req.sym_we     = 1'b1;
				req.sym_data   = sym_q;
				done           = 1'b1;
				res_now.status = htd_pkg::STAT_INSERTED;
			end
			S_DCHILD: begin
				child = bit_q ? rd.right : rd.left;
				if (child == '0) begin
					cursor_d       = '0;
					done           = 1'b1;
					res_now.status = htd_pkg::STAT_ABSENT;
				end else begin
					c_d         = child;
					req.rd_addr = child;
					state_d     = S_DLEAF;
				end
			end
			S_DLEAF: begin
				done = 1'b1;
				if (rd.left == '0 && rd.right == '0) begin
					cursor_d               = '0;
					res_now.status         = htd_pkg::STAT_SYMBOL;
					res_now.decoded_symbol = rd.sym;
				end else begin
					cursor_d       = c_q;
					res_now.status = htd_pkg::STAT_BIT;
				end
			end
			S_DONE: begin
				fin.valid = 1'b1;
				fin.res   = res_q;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// hand the result over now, or park it while the output is held
		if (done) begin
			fin.valid = 1'b1;
			fin.res   = res_now;
			if (out_free) begin
				state_d = S_IDLE;
			end else begin
				res_d   = res_now;
				state_d = S_DONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cursor_q <= '0;
			used_q   <= htd_pkg::CNT_W'(1);
		end else begin
			state_q  <= state_d;
			cursor_q <= cursor_d;
			used_q   <= used_d;
		end
	end

	always_ff @(posedge clk) begin
		p_q   <= p_d;
		c_q   <= c_d;
		k_q   <= k_d;
		res_q <= res_d;
		if (take) begin
			code_q <= item.code_bits;
			sym_q  <= item.symbol;
			bit_q  <= item.message_bit;
		end
	end

	`HTD_ASSERT_ALWAYS(a_used_range,
		used_q != '0 && used_q <= htd_pkg::CNT_W'(htd_pkg::NODE_COUNT))
	`HTD_ASSERT_NEXT(a_used_step, 1'b1,
		used_q == $past(used_q) || used_q == htd_pkg::CNT_W'($past(used_q) + 1'b1))
	`HTD_ASSERT_ALWAYS(a_fin_busy, !fin.valid || state_q != S_IDLE)

endmodule

`default_nettype wire

[rtl/huffman_tree_decoder.sv]
// top level of the huffman tree decoder: handshakes and result register
`timescale 1ns / 1ps
`default_nettype none

// Binary decoding tree in a node store of NODE_COUNT entries (child link and
// symbol memories, root links in flops, so reset needs no clearing pass).
// An insert beat walks its code from the root, allocating missing nodes; a
// decode beat steps the cursor one message bit and reports a symbol at a leaf.
// One item is worked at a time and item_stall is high until its result sits
// in the output register. A decode makes one registered read of the cursor
// node, then one of its child. An insert follows each existing node on its
// code with a read, then a compare, and allocates each missing node with a
// read, a link of the parent and a clear of the node; an empty code writes
// the root symbol. All of it runs through the single read port of the node
// store. A held result is parked in the sequencer while the downstream side
// stalls.
module huffman_tree_decoder (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire htd_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output htd_pkg::result_t      result
);

	htd_pkg::store_req_t req;
	htd_pkg::node_rd_t   rd;
	htd_pkg::fin_t       fin;
	logic                idle;
	logic                take;
	logic                out_free;
	logic                result_valid_q;
	htd_pkg::result_t    result_q;

	assign item_stall = !idle;
	assign take       = item_valid && idle;
	assign out_free   = !result_valid_q || !result_stall;

	htd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.take     (take),
		.out_free (out_free),
		.rd       (rd),
		.req      (req),
		.fin      (fin),
		.idle     (idle)
	);

	htd_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rd     (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fin.valid && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid && out_free) begin
			result_q <= fin.res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

[test/huffman_tree_decoder_tb.sv]
// testbench for the huffman tree decoder: directed table, random insert/decode traffic, checking
`timescale 1ns / 1ps
`default_nettype none

module huffman_tree_decoder_tb;
	import htd_pkg::*;

	localparam int RAND_ITEMS  = 1780;
	localparam int FILL_AT     = 1200;
	localparam int CALM_FROM   = 300;
	localparam int CALM_TO     = 520;
	localparam int HOLD_AT     = 600;
	localparam int HOLD_CYCLES = 300;
	localparam int PAUSE_AT    = 900;
	localparam int STALL_LIMIT = 3000;
	localparam int PRINT_CAP   = 20;
	localparam int NUM_STAT    = 5;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} drow_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// tree mirror
	logic [NODE_W-1:0] link_left  [NODE_COUNT];
	logic [NODE_W-1:0] link_right [NODE_COUNT];
	logic [SYM_W-1:0]  node_sym   [NODE_COUNT];
	int unsigned       used_nodes;
	logic [NODE_W-1:0] walk_pos;

	result_t due_results [$];
	drow_t   dir_rows    [$];
	int      sent_count  = 0;
	int      checked     = 0;
	int      mismatches  = 0;
	int      stat_seen [NUM_STAT];
	int      hold_left   = 0;
	bit      hold_done   = 1'b0;
	int      idle_cycles = 0;
	logic    calm;

	assign calm = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);

	huffman_tree_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// one item through the mirror tree, returns the result it must produce
	function automatic result_t tree_step(input item_t it);
		result_t           r;
		int                len;
		logic              dir;
		logic [NODE_W-1:0] p;
		logic [NODE_W-1:0] c;
		bit                full;
		r = '0;
		if (it.kind == KIND_INSERT) begin
			len = (it.code_len > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(it.code_len);
			p = '0;
			full = 1'b0;
			for (int k = 0; k < len && !full; k++) begin
				dir = it.code_bits[len - 1 - k];
				c = dir ? link_right[p] : link_left[p];
				if (c == '0) begin
					if (used_nodes >= NODE_COUNT) begin
						full = 1'b1;
					end else begin
						c = used_nodes[NODE_W-1:0];
						used_nodes++;
						link_left[c] = '0;
						link_right[c] = '0;
						node_sym[c] = '0;
						if (dir)
							link_right[p] = c;
						else
							link_left[p] = c;
					end
				end
				if (!full)
					p = c;
			end
			if (full) begin
				r.status = STAT_FULL;
			end else begin
				node_sym[p] = it.symbol;
				r.status = STAT_INSERTED;
			end
		end else begin
			c = it.message_bit ? link_right[walk_pos] : link_left[walk_pos];
			if (c == '0) begin
				r.status = STAT_ABSENT;
				walk_pos = '0;
			end else if (link_left[c] == '0 && link_right[c] == '0) begin
				r.status = STAT_SYMBOL;
				r.decoded_symbol = node_sym[c];
				walk_pos = '0;
			end else begin
				r.status = STAT_BIT;
				walk_pos = c;
			end
		end
		return r;
	endfunction

	function automatic item_t noisy_item();
		logic [31:0] r;
		r = $urandom;
		return r[$bits(item_t)-1:0];
	endfunction

	task automatic add_row(input logic kd, input logic [SYM_W-1:0] sy,
			input logic [CODE_W-1:0] cb, input logic [LEN_W-1:0] ln, input logic mb,
			input bit typed, input logic [STATUS_W-1:0] st);
		drow_t row;
		row.it = '{kind: kd, symbol: sy, code_bits: cb, code_len: ln, message_bit: mb};
		row.typed = typed;
		row.want = '{status: st, decoded_symbol: '0};
		dir_rows.push_back(row);
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (due_results.size() == 0) begin
			report_mismatch($sformatf("result beat %0d with nothing pending", checked));
			return;
		end
		want = due_results.pop_front();
		if (got.status !== want.status)
			report_mismatch($sformatf("result %0d status %0d, want %0d",
				checked, got.status, want.status));
		if (got.decoded_symbol !== want.decoded_symbol)
			report_mismatch($sformatf("result %0d symbol %02h, want %02h",
				checked, got.decoded_symbol, want.decoded_symbol));
		if (want.status < NUM_STAT)
			stat_seen[want.status]++;
		checked++;
	endtask

	// drive one item until the block takes it, then log what it must answer
	task automatic offer(input item_t it, input bit typed, input result_t want);
		result_t r;
		while (!calm && $urandom_range(99) < 28) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (item_stall);
		r = tree_step(it);
		due_results.push_back(typed ? want : r);
		sent_count++;
	endtask

	// receiver: stall pattern and result checking
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				check_result(result);
			if (!hold_done && sent_count >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= !calm && ($urandom_range(99) < 28);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("no beat moved for %0d cycles, %0d results pending",
					idle_cycles, due_results.size());
				$display("[huffman_tree_decoder] ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		item_t             it;
		logic [NODE_W-1:0] lc;
		logic [NODE_W-1:0] rc;
		int                pick;
		int                n;
		for (int i = 0; i < NODE_COUNT; i++) begin
			link_left[i] = '0;
			link_right[i] = '0;
			node_sym[i] = '0;
		end
		for (int i = 0; i < NUM_STAT; i++)
			stat_seen[i] = 0;
		used_nodes = 1;
		walk_pos = '0;

		// bare root first, then a small tree, then the longest codes
		add_row(KIND_DECODE, 8'h00, 16'h0000, 5'd0, 1'b0, 1'b1, STAT_ABSENT);
		add_row(KIND_DECODE, 8'hff, 16'hffff, 5'd31, 1'b1, 1'b1, STAT_ABSENT);
		add_row(KIND_INSERT, 8'ha5, 16'h0000, 5'd0, 1'b0, 1'b1, STAT_INSERTED);
		add_row(KIND_INSERT, 8'h5a, 16'h0001, 5'd1, 1'b0, 1'b1, STAT_INSERTED);
		add_row(KIND_DECODE, 8'h00, 16'h0000, 5'd0, 1'b1, 1'b0, STAT_BIT);
		add_row(KIND_DECODE, 8'h00, 16'h0000, 5'd0, 1'b0, 1'b1, STAT_ABSENT);
		add_row(KIND_INSERT, 8'h81, 16'h0001, 5'd2, 1'b1, 1'b1, STAT_INSERTED);
		add_row(KIND_DECODE, 8'h00, 16'h0000, 5'd0, 1'b0, 1'b0, STAT_BIT);
		add_row(KIND_DECODE, 8'h00, 16'h0000, 5'd0, 1'b1, 1'b0, STAT_BIT);
		add_row(KIND_DECODE, 8'h00, 16'h0000, 5'd0, 1'b0, 1'b0, STAT_BIT);
		add_row(KIND_DECODE, 8'h00, 16'h0000, 5'd0, 1'b0, 1'b0, STAT_BIT);
		add_row(KIND_INSERT, 8'hff, 16'hffff, 5'd16, 1'b0, 1'b1, STAT_INSERTED);
		add_row(KIND_INSERT, 8'h00, 16'h0000, 5'd16, 1'b1, 1'b1, STAT_INSERTED);
		// code length past the maximum is clipped
		add_row(KIND_INSERT, 8'h3c, 16'h8001, 5'd31, 1'b0, 1'b1, STAT_INSERTED);
		add_row(KIND_DECODE, 8'h00, 16'h0000, 5'd0, 1'b1, 1'b0, STAT_BIT);
		add_row(KIND_INSERT, 8'h0f, 16'h1234, 5'd0, 1'b1, 1'b1, STAT_INSERTED);
		// symbol on an inner node is stored but never comes out
		add_row(KIND_INSERT, 8'h99, 16'h0001, 5'd1, 1'b0, 1'b1, STAT_INSERTED);
		add_row(KIND_DECODE, 8'h00, 16'h0000, 5'd0, 1'b1, 1'b0, STAT_BIT);
		add_row(KIND_DECODE, 8'h00, 16'h0000, 5'd0, 1'b1, 1'b0, STAT_BIT);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			offer(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

		n = 0;
		while (n < RAND_ITEMS) begin
			if (n == PAUSE_AT) begin
				item_valid <= 1'b0;
				while (due_results.size() != 0)
					@(posedge clk);
			end
			if (n == FILL_AT) begin
				// long random codes until the store runs out
				while (used_nodes < NODE_COUNT) begin
					it = noisy_item();
					it.kind = KIND_INSERT;
					it.code_len = 5'd16;
					offer(it, 1'b0, '0);
					n++;
				end
			end
			it = noisy_item();
			pick = $urandom_range(99);
			if (pick < 12) begin
				it.kind = KIND_INSERT;
				pick = $urandom_range(99);
				if (pick < 80)
					it.code_len = LEN_W'($urandom_range(6, 1));
				else if (pick < 90)
					it.code_len = LEN_W'($urandom_range(16, 7));
				else if (pick < 95)
					it.code_len = '0;
				else
					it.code_len = LEN_W'($urandom_range(31, 17));
			end else begin
				// mostly follow branches that exist, some stray bits
				it.kind = KIND_DECODE;
				lc = link_left[walk_pos];
				rc = link_right[walk_pos];
				if ($urandom_range(99) < 15 || (lc == '0 && rc == '0))
					it.message_bit = 1'($urandom_range(1));
				else if (lc == '0)
					it.message_bit = 1'b1;
				else if (rc == '0)
					it.message_bit = 1'b0;
				else
					it.message_bit = 1'($urandom_range(1));
			end
			offer(it, 1'b0, '0);
			n++;
		end

		item_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("%0d items, %0d results: %0d symbols, %0d bits, %0d inserts, %0d full, %0d absent",
			sent_count, checked, stat_seen[STAT_SYMBOL], stat_seen[STAT_BIT],
			stat_seen[STAT_INSERTED], stat_seen[STAT_FULL], stat_seen[STAT_ABSENT]);
		$display("node store ended with %0d of %0d nodes, %0d mismatches",
			used_nodes, NODE_COUNT, mismatches);
		if (mismatches == 0)
			$display("[huffman_tree_decoder] OK");
		else
			$display("[huffman_tree_decoder] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
